FILE: hdl/bfct_pkg.sv
package bfct_pkg;

	// Plane set and fixed-point format
	localparam int NUM_PLANES = 6;
	localparam int FRAC_BITS  = 16;
	localparam int COEF_W     = 32;
	localparam int IDX_W      = 3;
	localparam int PROD_W     = 2 * COEF_W;
	// seven exact terms of at most 2^63 each fit with three guard bits
	localparam int ACC_W      = 2 * COEF_W + 3;

	// Stream widths
	localparam int S_TDATA_W  = 328;
	localparam int M_TDATA_W  = 8;

	// Item kinds carried in tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [COEF_W-1:0]        mag_t;

	typedef struct packed {
		coef_t a;
		coef_t b;
		coef_t c;
		coef_t d;
	} plane_t;

	// box as it enters the products: centre signed, half extents as magnitudes
	typedef struct packed {
		coef_t cx;
		coef_t cy;
		coef_t cz;
		mag_t  hx;
		mag_t  hy;
		mag_t  hz;
	} box_t;

	// register load enables for the three datapath stages
	typedef struct packed {
		logic adv1;
		logic adv2;
		logic adv3;
	} pipe_ctl_t;

	// magnitude of a signed word; the most negative value maps to 2^(COEF_W-1)
	function automatic mag_t abs_mag(coef_t v);
		mag_t r;
		if (v[COEF_W-1]) begin
			r = mag_t'(-v);
		end else begin
			r = mag_t'(v);
		end
		return r;
	endfunction

endpackage

FILE: hdl/bfct_plane_store.sv
module bfct_plane_store
	import bfct_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  plane_t wr_plane,
	output plane_t planes [NUM_PLANES]
);

	plane_t planes_q [NUM_PLANES];

	// one plane written per load word; an index past the set matches no entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				planes_q[p] <= '0;
			end
		end else if (wr_en) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				if (wr_idx == IDX_W'(p)) begin
					planes_q[p] <= wr_plane;
				end
			end
		end
	end

	assign planes = planes_q;

endmodule

FILE: hdl/bfct_plane_eval.sv
module bfct_plane_eval
	import bfct_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  box_t      box,
	input  plane_t    plane,
	output logic      reject
);

	// stage 1: exact products
	logic signed [PROD_W-1:0] cprod_x_s1, cprod_y_s1, cprod_z_s1;
	logic [PROD_W-1:0]        hprod_x_s1, hprod_y_s1, hprod_z_s1;
	coef_t                    d_s1;
	// stage 2: per-axis terms and scaled constant
	logic [ACC_W-1:0]         tx_s2, ty_s2, tz_s2, dd_s2;
	// stage 3: two partial sums
	logic [ACC_W-1:0]         u_s3, w_s3;
	logic [ACC_W-1:0]         total;

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			cprod_x_s1 <= plane.a * box.cx;
			cprod_y_s1 <= plane.b * box.cy;
			cprod_z_s1 <= plane.c * box.cz;
			hprod_x_s1 <= abs_mag(plane.a) * box.hx;
			hprod_y_s1 <= abs_mag(plane.b) * box.hy;
			hprod_z_s1 <= abs_mag(plane.c) * box.hz;
			d_s1       <= plane.d;
		end
	end

	// centre term sign-extended, extent term zero-extended
	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			tx_s2 <= ACC_W'(cprod_x_s1) + ACC_W'(hprod_x_s1);
			ty_s2 <= ACC_W'(cprod_y_s1) + ACC_W'(hprod_y_s1);
			tz_s2 <= ACC_W'(cprod_z_s1) + ACC_W'(hprod_z_s1);
			dd_s2 <= ACC_W'(d_s1) << FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv3) begin
			u_s3 <= tx_s2 + ty_s2;
			w_s3 <= tz_s2 + dd_s2;
		end
	end

	// largest corner value below zero culls against this plane
	assign total  = u_s3 + w_s3;
	assign reject = total[ACC_W-1];

endmodule

FILE: hdl/box_frustum_cull_test_core.sv
// Box against frustum cull test, six stored planes evaluated in parallel.
// Test words pass the product, term, partial-sum and output registers to a result word.
// Throughput: one word per cycle when unstalled; loads set a plane and give no result.
// The 36 product multipliers feeding the first stage set the cycle time.
// Reset (arst_n low) clears all valid bits and zeroes every stored plane.
module box_frustum_cull_test_core
	import bfct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// plane_index[2:0], coef_a, coef_b, coef_c, coef_d, center_x, center_y,
	// center_z, half_x, half_y, half_z (32 bits each), zero pad to 328
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// op[0]
	input  logic [0:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// visible[0], zero pad to 8
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic       in_acc;
	logic       op;
	logic [IDX_W-1:0] plane_index;
	plane_t     wr_plane;
	box_t       box;
	plane_t     planes [NUM_PLANES];
	pipe_ctl_t  ctl;
	logic [NUM_PLANES-1:0] reject;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic visible_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// word unpacking
	assign op          = s_axis_tuser[0];
	assign plane_index = s_axis_tdata[2:0];
	assign wr_plane.a  = s_axis_tdata[34:3];
	assign wr_plane.b  = s_axis_tdata[66:35];
	assign wr_plane.c  = s_axis_tdata[98:67];
	assign wr_plane.d  = s_axis_tdata[130:99];
	assign box.cx      = s_axis_tdata[162:131];
	assign box.cy      = s_axis_tdata[194:163];
	assign box.cz      = s_axis_tdata[226:195];
	assign box.hx      = abs_mag(coef_t'(s_axis_tdata[258:227]));
	assign box.hy      = abs_mag(coef_t'(s_axis_tdata[290:259]));
	assign box.hz      = abs_mag(coef_t'(s_axis_tdata[322:291]));

	// per-stage ready: a stage loads when empty or when its word moves on
	assign rdy4 = !vld_s4 || m_axis_tready;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign in_acc        = s_axis_tvalid && rdy1;

	assign ctl.adv1 = rdy1;
	assign ctl.adv2 = rdy2;
	assign ctl.adv3 = rdy3;

	// loads write at acceptance, so the next test already sees them
	bfct_plane_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc && (op == OP_LOAD)),
		.wr_idx   (plane_index),
		.wr_plane (wr_plane),
		.planes   (planes)
	);

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		bfct_plane_eval u_eval (
			.clk    (clk),
			.ctl    (ctl),
			.box    (box),
			.plane  (planes[p]),
			.reject (reject[p])
		);
	end

	// valid bits; only test words travel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= in_acc && (op == OP_TEST);
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (rdy4) begin
			visible_s4 <= ~|reject;
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, visible_s4};

`ifndef SYNTHESIS
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (op == OP_LOAD)) |=> !vld_s1)
		else $error("load word entered the result pipeline");

	a_test_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (op == OP_TEST)) |=> vld_s1)
		else $error("accepted test word lost at stage 1");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !rdy4) |=> vld_s3)
		else $error("stalled stage 3 word dropped");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && rdy3) |=> vld_s3)
		else $error("stage 2 word not passed to stage 3");
`endif

endmodule

FILE: verif/box_frustum_cull_test_core_test.sv
module box_frustum_cull_test_core_test;
	import bfct_pkg::*;

	localparam int    CYCLE_LIMIT = 200000;
	localparam int    DRAIN_CYCLES = 12;
	localparam coef_t ONE  = 32'sh0001_0000;
	localparam coef_t CMIN = 32'sh8000_0000;
	localparam coef_t CMAX = 32'sh7fff_ffff;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [0:0]           s_axis_tuser = OP_LOAD;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b1;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	// plane set as the block should hold it: a, b, c, d per plane
	coef_t plane_mem [NUM_PLANES][4] = '{default: '0};
	logic  expected_visible [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	int errors = 0;
	int n_loads = 0;
	int n_ignored = 0;
	int n_tests = 0;
	int n_visible = 0;
	int n_culled = 0;

	box_frustum_cull_test_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_visible.size());
			$display("box_frustum_cull_test_core: mismatch");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// exact positive-vertex test over all stored planes
	function automatic logic box_visible(coef_t cx, coef_t cy, coef_t cz,
		coef_t hx, coef_t hy, coef_t hz);
		logic signed [127:0] acc;
		longint ctr [3];
		longint half [3];
		longint cf;
		logic vis;
		ctr[0] = longint'(cx);
		ctr[1] = longint'(cy);
		ctr[2] = longint'(cz);
		half[0] = (hx < 0) ? -longint'(hx) : longint'(hx);
		half[1] = (hy < 0) ? -longint'(hy) : longint'(hy);
		half[2] = (hz < 0) ? -longint'(hz) : longint'(hz);
		vis = 1'b1;
		for (int p = 0; p < NUM_PLANES; p++) begin
			acc = '0;
			for (int k = 0; k < 3; k++) begin
				cf = longint'(plane_mem[p][k]);
				acc = acc + cf * ctr[k];
				acc = acc + ((cf < 0) ? -cf : cf) * half[k];
			end
			// d carries FRAC_BITS fewer fraction bits than the products
			acc = acc + longint'(plane_mem[p][3]) * (longint'(1) << FRAC_BITS);
			if (acc < 0) begin
				vis = 1'b0;
			end
		end
		return vis;
	endfunction

	function automatic coef_t rand_signed(int unsigned r);
		return coef_t'($urandom_range(2 * r) - r);
	endfunction

	// present one word; called at a falling edge, returns at a falling edge
	task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
		input coef_t f [10]);
		logic [S_TDATA_W-1:0] data;
		data = '0;
		data[IDX_W-1:0] = idx;
		for (int k = 0; k < 10; k++) begin
			data[IDX_W + k*COEF_W +: COEF_W] = f[k];
		end
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		// word taken at this edge
		if (op == OP_LOAD) begin
			n_loads++;
			if (idx < NUM_PLANES) begin
				for (int k = 0; k < 4; k++) begin
					plane_mem[idx][k] = f[k];
				end
			end else begin
				n_ignored++;
			end
		end else begin
			n_tests++;
			expected_visible.push_back(box_visible(f[4], f[5], f[6], f[7], f[8], f[9]));
		end
		@(negedge clk);
	endtask

	// box fields of a load word carry noise
	task automatic load_plane(input logic [IDX_W-1:0] idx, input coef_t a, input coef_t b,
		input coef_t c, input coef_t d);
		coef_t f [10];
		f[0] = a;
		f[1] = b;
		f[2] = c;
		f[3] = d;
		for (int k = 4; k < 10; k++) begin
			f[k] = coef_t'($urandom);
		end
		send_word(OP_LOAD, idx, f);
	endtask

	// plane fields and index of a test word carry noise
	task automatic test_box(input coef_t cx, input coef_t cy, input coef_t cz,
		input coef_t hx, input coef_t hy, input coef_t hz);
		coef_t f [10];
		for (int k = 0; k < 4; k++) begin
			f[k] = coef_t'($urandom);
		end
		f[4] = cx;
		f[5] = cy;
		f[6] = cz;
		f[7] = hx;
		f[8] = hy;
		f[9] = hz;
		send_word(OP_TEST, IDX_W'($urandom_range(7)), f);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_visible.size() == 0) begin
				$error("unexpected result word, visible=%0b", m_axis_tdata[0]);
				errors++;
			end else begin
				if (m_axis_tdata[0] !== expected_visible[0]) begin
					$error("visible: expected %0b, got %0b", expected_visible[0],
						m_axis_tdata[0]);
					errors++;
				end
				if (expected_visible[0]) begin
					n_visible++;
				end else begin
					n_culled++;
				end
				void'(expected_visible.pop_front());
			end
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		idle_pct  = send_pct;
		stall_pct = recv_pct;
	endtask

	// planes cleared by reset never cull
	task automatic test_cleared_planes();
		test_box(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
		test_box(CMIN, CMIN, CMIN, 32'sd0, 32'sd0, 32'sd0);
		test_box(32'sd0, 32'sd0, 32'sd0, CMAX, CMAX, CMAX);
	endtask

	// unit plane x >= 0, boundary hits, negative extents, cubes, extreme words
	task automatic test_field_extremes();
		load_plane(IDX_W'(0), ONE, 32'sd0, 32'sd0, 32'sd0);
		test_box(-32'sh0002_0000, 32'sd0, 32'sd0, 32'sh0002_0000, 32'sd0, 32'sd0);
		test_box(-32'sh0002_0001, 32'sd0, 32'sd0, 32'sh0002_0000, 32'sd0, 32'sd0);
		test_box(-32'sh0002_0000, 32'sd5, 32'sd7, -32'sh0002_0000, 32'sd0, 32'sd0);
		test_box(-32'sh0002_0001, 32'sd5, 32'sd7, -32'sh0002_0000, 32'sd0, 32'sd0);
		test_box(-32'sh0003_0000, CMAX, CMIN, 32'sh0001_0000, 32'sh0001_0000,
			32'sh0001_0000);
		test_box(-32'sh0000_8000, 32'sd0, 32'sd0, -32'sh0000_8000, -32'sh0000_8000,
			-32'sh0000_8000);
		load_plane(IDX_W'(1), CMIN, CMAX, CMIN, CMIN);
		load_plane(IDX_W'(5), CMAX, CMAX, CMAX, CMAX);
		test_box(CMAX, CMIN, CMAX, CMIN, CMIN, CMIN);
		test_box(CMIN, CMAX, CMIN, 32'sd0, 32'sd0, 32'sd0);
		test_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
		load_plane(IDX_W'(3), CMIN, CMIN, CMIN, CMIN);
		test_box(CMAX, CMAX, CMAX, 32'sd0, 32'sd0, 32'sd0);
		test_box(CMIN, CMIN, CMIN, 32'sd1, 32'sd1, 32'sd1);
	endtask

	// clear slots 2 and 4; loads to slots past the plane set change nothing
	task automatic test_out_of_range_loads();
		load_plane(IDX_W'(2), 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		load_plane(IDX_W'(4), 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		load_plane(IDX_W'(6), 32'sd0, 32'sd0, 32'sd0, CMIN);
		load_plane(IDX_W'(7), CMAX, CMIN, CMAX, CMIN);
		test_box(32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		test_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
	endtask

	// one axis plane, boxes placed just inside, on, or just outside it
	task automatic test_touching_planes();
		coef_t n [3];
		coef_t ctr [3];
		coef_t hh [3];
		coef_t d;
		int ax;
		int delta;
		longint pos;
		for (int p = 0; p < NUM_PLANES; p++) begin
			load_plane(IDX_W'(p), 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		end
		for (int r = 0; r < 4; r++) begin
			ax = $urandom_range(2);
			n = '{default: '0};
			n[ax] = $urandom_range(1) ? ONE : -ONE;
			d = rand_signed(32'h0040_0000);
			load_plane(IDX_W'(2), n[0], n[1], n[2], d);
			for (int i = 0; i < 15; i++) begin
				for (int k = 0; k < 3; k++) begin
					hh[k]  = rand_signed(32'h0010_0000);
					ctr[k] = coef_t'($urandom);
				end
				delta = int'($urandom_range(2)) - 1;
				pos = -longint'(d) - ((hh[ax] < 0) ? -longint'(hh[ax]) : longint'(hh[ax]))
					+ delta;
				ctr[ax] = (n[ax] < 0) ? coef_t'(-pos) : coef_t'(pos);
				test_box(ctr[0], ctr[1], ctr[2], hh[0], hh[1], hh[2]);
			end
		end
	endtask

	// mostly moderate planes and boxes so both outcomes are common
	task automatic test_random_traffic(input int count);
		coef_t h;
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 12) begin
				if ($urandom_range(3) == 0) begin
					load_plane(IDX_W'($urandom_range(7)), coef_t'($urandom), coef_t'($urandom),
						coef_t'($urandom), coef_t'($urandom));
				end else begin
					load_plane(IDX_W'($urandom_range(7)), rand_signed(32'h0001_0000),
						rand_signed(32'h0001_0000), rand_signed(32'h0001_0000),
						rand_signed(32'h0008_0000) + 32'sh0018_0000);
				end
			end else begin
				case ($urandom_range(9))
					0: begin
						test_box(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
							coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
					end
					1: begin
						h = rand_signed(32'h0008_0000);
						test_box(rand_signed(32'h0020_0000), rand_signed(32'h0020_0000),
							rand_signed(32'h0020_0000), h, h, h);
					end
					default: begin
						test_box(rand_signed(32'h0020_0000), rand_signed(32'h0020_0000),
							rand_signed(32'h0020_0000), rand_signed(32'h0008_0000),
							rand_signed(32'h0008_0000), rand_signed(32'h0008_0000));
					end
				endcase
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(0, 0);
		test_cleared_planes();
		test_field_extremes();
		test_out_of_range_loads();
		test_touching_planes();
		test_random_traffic(270);
		set_idling(52, 0);
		test_random_traffic(270);
		set_idling(0, 52);
		test_random_traffic(270);
		set_idling(11, 11);
		test_random_traffic(270);
		s_axis_tvalid <= 1'b0;

		while (expected_visible.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d plane loads (%0d to unused slots) and %0d box tests",
			n_loads, n_ignored, n_tests);
		$display("boxes seen visible %0d, culled %0d, over four idle/stall phases",
			n_visible, n_culled);
		if (errors == 0) begin
			$display("box_frustum_cull_test_core: match");
		end else begin
			$display("box_frustum_cull_test_core: mismatch");
		end
		$finish;
	end

endmodule
